// ----- design/text_console_with_pointer_defines.svh -----
// ----------------------------------------------------------------------------
// Text console with pointer: assertion macros
// Shared concurrent assertion forms used by the console RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WITH_POINTER_DEFINES_SVH
`define TEXT_CONSOLE_WITH_POINTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define TCP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/tcp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console with pointer: shared package
// Command codes, queue entry types and screen constants.
// ----------------------------------------------------------------------------
package tcp_pkg;

	// Default screen geometry
	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	// Depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Input operation codes
	localparam logic [1:0] OP_PUT  = 2'd0;
	localparam logic [1:0] OP_MOVE = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	// Classified command kinds
	localparam logic [2:0] KIND_NOP     = 3'd0;
	localparam logic [2:0] KIND_PUT     = 3'd1;
	localparam logic [2:0] KIND_NEWLINE = 3'd2;
	localparam logic [2:0] KIND_MOVE    = 3'd3;
	localparam logic [2:0] KIND_READ    = 3'd4;

	// Character and attribute constants
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_BLANK   = 8'h20;
	localparam logic [7:0] ATTR_RESET   = 8'h07;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  char_code;
		logic [7:0]  delta_x;
		logic [7:0]  delta_y;
		logic [10:0] cell_index;
	} tcp_cmd_t;

	// Head of the command queue as seen by the back end
	typedef struct packed {
		logic     valid;
		tcp_cmd_t cmd;
	} tcp_head_t;

	// Back-end feedback to the front end
	typedef struct packed {
		logic pop;
		logic init_busy;
	} tcp_back_stat_t;

	// Swap foreground and background nibbles of an attribute byte
	function automatic logic [7:0] swap_nib(input logic [7:0] attr);
		return {attr[3:0], attr[7:4]};
	endfunction

endpackage

// ----- design/tcp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console front end
// Accepts input transactions, classifies them into commands and queues them.
// ----------------------------------------------------------------------------
module tcp_front import tcp_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [1:0]            operation,
	input  logic [7:0]            char_code,
	input  logic signed [7:0]     delta_x,
	input  logic signed [7:0]     delta_y,
	input  logic [10:0]           cell_index,
	output tcp_head_t             head,
	input  tcp_back_stat_t        bstat
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int QAW   = $clog2(QUEUE_DEPTH);

	tcp_cmd_t         queue_q [QUEUE_DEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     count_q;
	tcp_cmd_t         cmd_in;
	logic             accept;

	// Classify the incoming transaction
	always_comb begin
		cmd_in.char_code  = char_code;
		cmd_in.delta_x    = delta_x;
		cmd_in.delta_y    = delta_y;
		cmd_in.cell_index = cell_index;
		case (operation)
			OP_PUT: begin
				cmd_in.kind = (char_code == CHAR_NEWLINE) ? KIND_NEWLINE : KIND_PUT;
			end
			OP_MOVE: begin
				cmd_in.kind = KIND_MOVE;
			end
			OP_READ: begin
				cmd_in.kind = (int'(cell_index) < CELLS) ? KIND_READ : KIND_NOP;
			end
			default: begin
				cmd_in.kind = KIND_NOP;
			end
		endcase
	end

	// Hold off input while the queue is full or the screen is being initialized
	assign full   = (count_q == (QAW+1)'(QUEUE_DEPTH)) || bstat.init_busy;
	assign accept = push && !full;

	assign head.valid = (count_q != '0);
	assign head.cmd   = queue_q[rd_ptr_q];

	// Store queue entries
	always_ff @(posedge clk) begin
		if (accept) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Advance queue pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (bstat.pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (accept && !bstat.pop) begin
				count_q <= count_q + 1'b1;
			end else if (!accept && bstat.pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/tcp_back.sv -----
`timescale 1ns / 1ps
`include "text_console_with_pointer_defines.svh"
// ----------------------------------------------------------------------------
// Text console back end
// Owns the screen memory, the write cursor and the pointer; executes queued
// commands and holds one finished result for the output side.
// ----------------------------------------------------------------------------
module tcp_back import tcp_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tcp_head_t       head,
	output tcp_back_stat_t  bstat,
	output logic            empty,
	input  logic            pop,
	output logic [15:0]     read_data,
	output logic [6:0]      cursor_column,
	output logic [4:0]      cursor_row,
	output logic [6:0]      mouse_column,
	output logic [4:0]      mouse_row
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam int PTR_RESET_ADDR = (ROWS / 2) * COLUMNS + COLUMNS / 2;

	localparam logic [2:0] ST_INIT     = 3'd0;
	localparam logic [2:0] ST_IDLE     = 3'd1;
	localparam logic [2:0] ST_READ     = 3'd2;
	localparam logic [2:0] ST_CLEAR    = 3'd3;
	localparam logic [2:0] ST_MV_SWAP1 = 3'd4;
	localparam logic [2:0] ST_MV_READ2 = 3'd5;
	localparam logic [2:0] ST_MV_SWAP2 = 3'd6;

	// Screen memory, split into attribute and character bytes
	logic [7:0] char_mem [CELLS];
	logic [7:0] attr_mem [CELLS];
	logic [7:0] char_rd_q;
	logic [7:0] attr_rd_q;

	logic [2:0]    state_q, state_d;
	logic [AW-1:0] sweep_q, sweep_d;
	logic [CW-1:0] col_q, col_d;
	logic [RW-1:0] row_q, row_d;
	logic [AW-1:0] cur_addr_q, cur_addr_d;
	logic [CW-1:0] ptr_col_q, ptr_col_d;
	logic [RW-1:0] ptr_row_q, ptr_row_d;
	logic [AW-1:0] ptr_addr_q, ptr_addr_d;

	logic          res_valid_q;
	logic [15:0]   res_data_q;
	logic [6:0]    res_col_q;
	logic [4:0]    res_row_q;
	logic [6:0]    res_mcol_q;
	logic [4:0]    res_mrow_q;

	logic          take;
	logic          finish;
	logic [15:0]   res_data_d;
	logic          sweep_last;
	logic [CW:0]   col_inc;
	logic [RW:0]   row_inc;
	logic signed [9:0] sum_x;
	logic signed [9:0] sum_y;

	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic          char_we;
	logic          attr_we;
	logic [7:0]    wchar;
	logic [7:0]    wattr;

	// Take a command only when the result slot is free or drains this cycle
	assign take       = (state_q == ST_IDLE) && head.valid && (!res_valid_q || pop);
	assign sweep_last = (sweep_q == AW'(CELLS - 1));
	assign col_inc    = {1'b0, col_q} + 1'b1;
	assign row_inc    = {1'b0, row_q} + 1'b1;
	assign sum_x      = 10'($signed({1'b0, ptr_col_q})) + 10'($signed(head.cmd.delta_x));
	assign sum_y      = 10'($signed({1'b0, ptr_row_q})) - 10'($signed(head.cmd.delta_y));

	assign bstat.pop       = take;
	assign bstat.init_busy = (state_q == ST_INIT);

	// Next-state logic and memory port control
	always_comb begin
		state_d    = state_q;
		sweep_d    = sweep_q;
		col_d      = col_q;
		row_d      = row_q;
		cur_addr_d = cur_addr_q;
		ptr_col_d  = ptr_col_q;
		ptr_row_d  = ptr_row_q;
		ptr_addr_d = ptr_addr_q;
		finish     = 1'b0;
		res_data_d = '0;
		raddr      = ptr_addr_q;
		waddr      = sweep_q;
		char_we    = 1'b0;
		attr_we    = 1'b0;
		wchar      = CHAR_BLANK;
		wattr      = swap_nib(attr_rd_q);
		case (state_q)
			ST_INIT: begin
				char_we = 1'b1;
				attr_we = 1'b1;
				wattr   = (sweep_q == AW'(PTR_RESET_ADDR)) ? swap_nib(ATTR_RESET) : ATTR_RESET;
				sweep_d = sweep_q + 1'b1;
				if (sweep_last) begin
					sweep_d = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (take) begin
					case (head.cmd.kind)
						KIND_PUT: begin
							char_we = 1'b1;
							waddr   = cur_addr_q;
							wchar   = head.cmd.char_code;
							if (col_inc == (CW+1)'(COLUMNS)) begin
								col_d = '0;
								row_d = row_inc[RW-1:0];
							end else begin
								col_d = col_inc[CW-1:0];
							end
							cur_addr_d = cur_addr_q + 1'b1;
							if ((col_inc == (CW+1)'(COLUMNS)) && (row_inc == (RW+1)'(ROWS))) begin
								col_d      = '0;
								row_d      = '0;
								cur_addr_d = '0;
								state_d    = ST_CLEAR;
							end else begin
								finish = 1'b1;
							end
						end
						KIND_NEWLINE: begin
							if (row_inc == (RW+1)'(ROWS)) begin
								col_d      = '0;
								row_d      = '0;
								cur_addr_d = '0;
								state_d    = ST_CLEAR;
							end else begin
								col_d      = '0;
								row_d      = row_inc[RW-1:0];
								cur_addr_d = cur_addr_q - AW'(col_q) + AW'(COLUMNS);
								finish     = 1'b1;
							end
						end
						KIND_MOVE: begin
							// Read old pointer cell, clamp the new position to the screen
							raddr = ptr_addr_q;
							if (sum_x[9]) begin
								ptr_col_d = '0;
							end else if (sum_x > 10'(COLUMNS - 1)) begin
								ptr_col_d = CW'(COLUMNS - 1);
							end else begin
								ptr_col_d = CW'(sum_x);
							end
							if (sum_y[9]) begin
								ptr_row_d = '0;
							end else if (sum_y > 10'(ROWS - 1)) begin
								ptr_row_d = RW'(ROWS - 1);
							end else begin
								ptr_row_d = RW'(sum_y);
							end
							state_d = ST_MV_SWAP1;
						end
						KIND_READ: begin
							raddr   = AW'(head.cmd.cell_index);
							state_d = ST_READ;
						end
						default: begin
							finish = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				res_data_d = {attr_rd_q, char_rd_q};
				finish     = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_CLEAR: begin
				char_we = 1'b1;
				sweep_d = sweep_q + 1'b1;
				if (sweep_last) begin
					sweep_d = '0;
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_MV_SWAP1: begin
				attr_we    = 1'b1;
				waddr      = ptr_addr_q;
				ptr_addr_d = AW'(32'(ptr_row_q) * COLUMNS + 32'(ptr_col_q));
				state_d    = ST_MV_READ2;
			end
			ST_MV_READ2: begin
				raddr   = ptr_addr_q;
				state_d = ST_MV_SWAP2;
			end
			ST_MV_SWAP2: begin
				attr_we = 1'b1;
				waddr   = ptr_addr_q;
				finish  = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Screen memory ports
	always_ff @(posedge clk) begin
		if (char_we) begin
			char_mem[waddr] <= wchar;
		end
		char_rd_q <= char_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (attr_we) begin
			attr_mem[waddr] <= wattr;
		end
		attr_rd_q <= attr_mem[raddr];
	end

	// Control and cursor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			sweep_q     <= '0;
			col_q       <= '0;
			row_q       <= '0;
			cur_addr_q  <= '0;
			ptr_col_q   <= CW'(COLUMNS / 2);
			ptr_row_q   <= RW'(ROWS / 2);
			ptr_addr_q  <= AW'(PTR_RESET_ADDR);
			res_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			sweep_q    <= sweep_d;
			col_q      <= col_d;
			row_q      <= row_d;
			cur_addr_q <= cur_addr_d;
			ptr_col_q  <= ptr_col_d;
			ptr_row_q  <= ptr_row_d;
			ptr_addr_q <= ptr_addr_d;
			if (finish) begin
				res_valid_q <= 1'b1;
			end else if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Capture the finished result
	always_ff @(posedge clk) begin
		if (finish) begin
			res_data_q <= res_data_d;
			res_col_q  <= 7'(col_d);
			res_row_q  <= 5'(row_d);
			res_mcol_q <= 7'(ptr_col_d);
			res_mrow_q <= 5'(ptr_row_d);
		end
	end

	assign empty         = !res_valid_q;
	assign read_data     = res_data_q;
	assign cursor_column = res_col_q;
	assign cursor_row    = res_row_q;
	assign mouse_column  = res_mcol_q;
	assign mouse_row     = res_mrow_q;

	// Checks
	`TCP_ASSERT_NOW(a_cursor_range, clk, arst_n, 1'b1,
		(int'(col_q) < COLUMNS) && (int'(row_q) < ROWS), "write cursor off screen")
	`TCP_ASSERT_NOW(a_pointer_range, clk, arst_n, 1'b1,
		(int'(ptr_col_q) < COLUMNS) && (int'(ptr_row_q) < ROWS), "pointer off screen")
	`TCP_ASSERT_NOW(a_cursor_addr, clk, arst_n, 1'b1,
		cur_addr_q == AW'(32'(row_q) * COLUMNS + 32'(col_q)), "cursor address out of step")
	`TCP_ASSERT_NOW(a_no_result_in_init, clk, arst_n, state_q == ST_INIT,
		!res_valid_q && !take, "activity during screen initialization")
	`TCP_ASSERT_NEXT(a_finish_fills_slot, clk, arst_n, finish, res_valid_q,
		"finished command lost its result")

endmodule

// ----- design/text_console_with_pointer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console with pointer
// Text screen with write cursor and highlighted pointer cell.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive the command fields and raise push; the
//   transaction is taken at a clock edge with push high and full low.
//   Output side is a queue: while empty is low the oldest result is on the
//   result ports; raise pop to take it. Every input gives exactly one result.
//   A four-entry command queue separates the decoder from the screen engine,
//   and one result register separates the engine from the output side.
//   Engine steps: an unused or out-of-range read, a put and a newline end
//   in the idle state; a read cell reads the memory, then returns the cell;
//   a pointer move reads and swaps the old pointer cell, then the new one;
//   a put or newline off the bottom row adds a pass that blanks the
//   character memory. One memory port pair sets these steps. After reset
//   an initialization pass fills the screen; full stays high until it ends.
//   When the receiver does not pop, the result register holds, the engine
//   stops taking commands, and the queue fills until full rises.
// ----------------------------------------------------------------------------
module text_console_with_pointer import tcp_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        operation,
	input  logic [7:0]        char_code,
	input  logic signed [7:0] delta_x,
	input  logic signed [7:0] delta_y,
	input  logic [10:0]       cell_index,
	output logic              empty,
	input  logic              pop,
	output logic [15:0]       read_data,
	output logic [6:0]        cursor_column,
	output logic [4:0]        cursor_row,
	output logic [6:0]        mouse_column,
	output logic [4:0]        mouse_row
);

	tcp_head_t      head;
	tcp_back_stat_t bstat;

	// Decode and queue commands
	tcp_front #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.operation  (operation),
		.char_code  (char_code),
		.delta_x    (delta_x),
		.delta_y    (delta_y),
		.cell_index (cell_index),
		.head       (head),
		.bstat      (bstat)
	);

	// Execute commands against the screen
	tcp_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.bstat         (bstat),
		.empty         (empty),
		.pop           (pop),
		.read_data     (read_data),
		.cursor_column (cursor_column),
		.cursor_row    (cursor_row),
		.mouse_column  (mouse_column),
		.mouse_row     (mouse_row)
	);

endmodule
